// ----- design/tdu_pkg.sv -----
// shared types and constants for the tick driven uart
package tdu_pkg;

  localparam int unsigned STEP_W     = 4;
  localparam int unsigned PERIOD_W   = 6;
  localparam int unsigned RX_FIRST_W = 7;
  localparam int unsigned TX_FIRST_W = 6;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CNT_W      = 4;

  localparam logic [STEP_W-1:0]     STEP_RST     = 4'd3;
  localparam logic [PERIOD_W-1:0]   PERIOD_RST   = 6'd10;
  localparam logic [RX_FIRST_W-1:0] RX_FIRST_RST = 7'd15;
  localparam logic [TX_FIRST_W-1:0] TX_FIRST_RST = 6'd3;

  localparam logic [CNT_W-1:0] RX_DATA_BITS = 4'd8;
  localparam logic [CNT_W-1:0] TX_START_BIT = 4'd0;
  localparam logic [CNT_W-1:0] TX_LAST_DATA = 4'd8;
  localparam logic [CNT_W-1:0] TX_STOP_BIT  = 4'd9;
  localparam logic [CNT_W-1:0] TX_END_BIT   = 4'd10;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_EDGE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP      = 2'd0,
    CFG_BIT_PERIOD      = 2'd1,
    CFG_RX_FIRST_SAMPLE = 2'd2,
    CFG_TX_FIRST_EDGE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic       action;
    logic       rx_level;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_line;
    logic       tx_taken;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       rx_busy;
    logic       tx_busy;
  } out_item_t;

  typedef struct packed {
    logic adv;
    logic load;
  } phase_ctl_t;

endpackage

// ----- design/tdu_phase.sv -----
// phase accumulator and bit event mark for one side of the uart
module tdu_phase #(
  parameter int unsigned PHASE_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tdu_pkg::phase_ctl_t          ctl_i,
  input  logic [PHASE_BITS-1:0]        first_i,
  input  logic [tdu_pkg::STEP_W-1:0]   step_i,
  input  logic [tdu_pkg::PERIOD_W-1:0] period_i,
  output logic                         fire_o
);
  import tdu_pkg::*;

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PHASE_BITS-1:0] mark_q, mark_d;
  logic [PHASE_BITS-1:0] phase_sum;

  assign phase_sum = phase_q + {{(PHASE_BITS-STEP_W){1'b0}}, step_i};
  assign fire_o    = ctl_i.adv && (phase_sum >= mark_q);

  always_comb begin
    phase_d = phase_q;
    mark_d  = mark_q;
    if (ctl_i.load) begin
      phase_d = '0;
      mark_d  = first_i;
    end else if (ctl_i.adv) begin
      phase_d = phase_sum;
      if (fire_o) begin
        mark_d = mark_q + {{(PHASE_BITS-PERIOD_W){1'b0}}, period_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      mark_q  <= '0;
    end else begin
      phase_q <= phase_d;
      mark_q  <= mark_d;
    end
  end

endmodule

// ----- design/tick_driven_uart_fractional_timing.sv -----
// top level of the tick driven 8n1 uart with fractional bit timing
//
// each input item is either a timer tick or a falling edge seen on the
// receive line; each accepted item yields exactly one result item that
// reports the transmit line level, byte take and receive status after it.
// input and result channels use valid/ready. the item is processed in the
// cycle it is accepted and its result sits in the output register on the
// next cycle; throughput is one item per cycle while results are taken.
// the input stays ready while a result waits as long as the result is
// taken in the same cycle; if the receiver stalls, one result is held and
// the input ready drops until it is taken. no other work is lost.
// both phase accumulators feed the output register through a phase adder
// and compare each; each also adds the bit period to its mark.
// the four timing registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i;
// the user writes them only while no item is in flight; the block does not enforce it.
// reset returns the line to idle high, both sides to idle and the timing
// registers to their default values; no clearing pass is needed.
module tick_driven_uart_fractional_timing #(
  parameter int unsigned PHASE_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tdu_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tdu_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [tdu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tdu_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import tdu_pkg::*;

  logic [STEP_W-1:0]     step_q;
  logic [PERIOD_W-1:0]   period_q;
  logic [RX_FIRST_W-1:0] rx_first_q;
  logic [TX_FIRST_W-1:0] tx_first_q;

  logic             rx_active_q, rx_active_d;
  logic [CNT_W-1:0] rx_cnt_q, rx_cnt_d;
  logic [7:0]       rx_shift_q, rx_shift_d;
  logic             tx_active_q, tx_active_d;
  logic [CNT_W-1:0] tx_cnt_q, tx_cnt_d;
  logic [7:0]       tx_shift_q, tx_shift_d;
  logic             tx_level_q, tx_level_d;

  logic      out_valid_q;
  out_item_t out_item_q, out_item_d;

  logic       accept, tick, edge_ev;
  logic       rx_fire, tx_fire;
  logic       tx_take, rx_got;
  phase_ctl_t rx_ctl, tx_ctl;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign tick        = accept && (in_item_i.action == ACT_TICK);
  assign edge_ev     = accept && (in_item_i.action == ACT_EDGE);
  assign tx_take     = tick && !tx_active_q && in_item_i.tx_valid && (in_item_i.tx_byte != 8'd0);

  assign rx_ctl.adv  = tick && rx_active_q;
  assign rx_ctl.load = edge_ev && !rx_active_q;
  assign tx_ctl.adv  = tick && tx_active_q;
  assign tx_ctl.load = tx_take;

  tdu_phase #(
    .PHASE_BITS(PHASE_BITS)
  ) u_rx_phase (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (rx_ctl),
    .first_i  ({{(PHASE_BITS-RX_FIRST_W){1'b0}}, rx_first_q}),
    .step_i   (step_q),
    .period_i (period_q),
    .fire_o   (rx_fire)
  );

  tdu_phase #(
    .PHASE_BITS(PHASE_BITS)
  ) u_tx_phase (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (tx_ctl),
    .first_i  ({{(PHASE_BITS-TX_FIRST_W){1'b0}}, tx_first_q}),
    .step_i   (step_q),
    .period_i (period_q),
    .fire_o   (tx_fire)
  );

  // receiver
  always_comb begin
    rx_active_d = rx_active_q;
    rx_cnt_d    = rx_cnt_q;
    rx_shift_d  = rx_shift_q;
    rx_got      = 1'b0;
    if (rx_ctl.load) begin
      rx_active_d = 1'b1;
      rx_cnt_d    = '0;
      rx_shift_d  = '0;
    end else if (rx_fire) begin
      if (rx_cnt_q < RX_DATA_BITS) begin
        rx_shift_d = {in_item_i.rx_level, rx_shift_q[7:1]};
        rx_cnt_d   = rx_cnt_q + CNT_W'(1);
      end else begin
        rx_got      = in_item_i.rx_level;
        rx_active_d = 1'b0;
      end
    end
  end

  // transmitter
  always_comb begin
    tx_active_d = tx_active_q;
    tx_cnt_d    = tx_cnt_q;
    tx_shift_d  = tx_shift_q;
    tx_level_d  = tx_level_q;
    if (tx_take) begin
      tx_active_d = 1'b1;
      tx_cnt_d    = '0;
      tx_shift_d  = in_item_i.tx_byte;
    end else if (tx_fire) begin
      if (tx_cnt_q == TX_START_BIT) begin
        tx_level_d = 1'b0;
        tx_cnt_d   = tx_cnt_q + CNT_W'(1);
      end else if (tx_cnt_q <= TX_LAST_DATA) begin
        tx_level_d = tx_shift_q[0];
        tx_shift_d = {1'b0, tx_shift_q[7:1]};
        tx_cnt_d   = tx_cnt_q + CNT_W'(1);
      end else if (tx_cnt_q == TX_STOP_BIT) begin
        tx_level_d = 1'b1;
        tx_cnt_d   = tx_cnt_q + CNT_W'(1);
      end else begin
        tx_active_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_item_d.tx_line  = tx_level_d;
    out_item_d.tx_taken = tx_take;
    out_item_d.rx_valid = rx_got;
    out_item_d.rx_data  = rx_got ? rx_shift_q : 8'd0;
    out_item_d.rx_busy  = rx_active_d;
    out_item_d.tx_busy  = tx_active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= STEP_RST;
      period_q   <= PERIOD_RST;
      rx_first_q <= RX_FIRST_RST;
      tx_first_q <= TX_FIRST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PHASE_STEP:      step_q     <= cfg_wdata_i[STEP_W-1:0];
        CFG_BIT_PERIOD:      period_q   <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_RX_FIRST_SAMPLE: rx_first_q <= cfg_wdata_i[RX_FIRST_W-1:0];
        CFG_TX_FIRST_EDGE:   tx_first_q <= cfg_wdata_i[TX_FIRST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_active_q <= 1'b0;
      rx_cnt_q    <= '0;
      rx_shift_q  <= '0;
      tx_active_q <= 1'b0;
      tx_cnt_q    <= '0;
      tx_shift_q  <= '0;
      tx_level_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      rx_active_q <= rx_active_d;
      rx_cnt_q    <= rx_cnt_d;
      rx_shift_q  <= rx_shift_d;
      tx_active_q <= tx_active_d;
      tx_cnt_q    <= tx_cnt_d;
      tx_shift_q  <= tx_shift_d;
      tx_level_q  <= tx_level_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_rx_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_cnt_q <= RX_DATA_BITS)
    else $error("rx bit count out of range");

  a_tx_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_cnt_q <= TX_END_BIT)
    else $error("tx bit count out of range");

  a_tx_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tx_active_q |-> tx_level_q)
    else $error("tx line low while idle");

  a_rx_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.rx_valid |-> !out_item_o.rx_busy)
    else $error("rx byte delivered while still busy");

  a_tx_taken_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_take |=> tx_active_q && (tx_cnt_q == TX_START_BIT))
    else $error("tx byte taken without starting");
`endif

endmodule

// ----- sim/tb_tick_driven_uart_fractional_timing.sv -----
// self-checking testbench for the tick driven 8n1 uart with fractional bit timing
`timescale 1ns / 1ps

module tb_tick_driven_uart_fractional_timing;
  import tdu_pkg::*;

  localparam int unsigned PH_W        = 10;
  localparam int unsigned RAND_ITEMS  = 1350;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_PRINTS  = 40;
  localparam int unsigned IN_W        = $bits(in_item_t);

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  class uart_scoreboard;
    logic [PH_W-1:0]  step_ph, period_ph, rx_first_ph, tx_first_ph;
    logic             rx_on, tx_on, line_lvl;
    logic [CNT_W-1:0] rx_cnt, tx_cnt;
    logic [PH_W-1:0]  rx_ph, rx_mark, tx_ph, tx_mark;
    logic [7:0]       rx_sr, tx_sr;
    out_item_t        line_status_q[$];
    int               errors;
    int               checked;

    function new();
      step_ph     = PH_W'(STEP_RST);
      period_ph   = PH_W'(PERIOD_RST);
      rx_first_ph = PH_W'(RX_FIRST_RST);
      tx_first_ph = PH_W'(TX_FIRST_RST);
      rx_on       = 1'b0;
      tx_on       = 1'b0;
      line_lvl    = 1'b1;
      rx_cnt      = '0;
      tx_cnt      = '0;
      rx_ph       = '0;
      rx_mark     = '0;
      tx_ph       = '0;
      tx_mark     = '0;
      rx_sr       = '0;
      tx_sr       = '0;
      errors      = 0;
      checked     = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_PHASE_STEP:      step_ph     = PH_W'(v[STEP_W-1:0]);
        CFG_BIT_PERIOD:      period_ph   = PH_W'(v[PERIOD_W-1:0]);
        CFG_RX_FIRST_SAMPLE: rx_first_ph = PH_W'(v[RX_FIRST_W-1:0]);
        CFG_TX_FIRST_EDGE:   tx_first_ph = PH_W'(v[TX_FIRST_W-1:0]);
        default: ;
      endcase
    endfunction

    function int pending();
      return line_status_q.size();
    endfunction

    function void note_item(in_item_t it);
      out_item_t res;
      res = '0;
      if (it.action == ACT_EDGE) begin
        if (!rx_on) begin
          rx_sr   = '0;
          rx_cnt  = '0;
          rx_ph   = '0;
          rx_mark = rx_first_ph;
          rx_on   = 1'b1;
        end
      end else begin
        if (rx_on) begin
          rx_ph = rx_ph + step_ph;
          if (rx_ph >= rx_mark) begin
            rx_mark = rx_mark + period_ph;
            if (rx_cnt < RX_DATA_BITS) begin
              rx_sr  = {it.rx_level, rx_sr[7:1]};
              rx_cnt = rx_cnt + CNT_W'(1);
            end else begin
              if (it.rx_level) begin
                res.rx_valid = 1'b1;
                res.rx_data  = rx_sr;
              end
              rx_on = 1'b0;
            end
          end
        end
        if (!tx_on) begin
          if (it.tx_valid && it.tx_byte != 8'h00) begin
            tx_sr        = it.tx_byte;
            tx_cnt       = '0;
            tx_ph        = '0;
            tx_mark      = tx_first_ph;
            tx_on        = 1'b1;
            res.tx_taken = 1'b1;
          end
        end else begin
          tx_ph = tx_ph + step_ph;
          if (tx_ph >= tx_mark) begin
            tx_mark = tx_mark + period_ph;
            if (tx_cnt == TX_START_BIT) begin
              line_lvl = 1'b0;
            end else if (tx_cnt <= TX_LAST_DATA) begin
              line_lvl = tx_sr[0];
              tx_sr    = tx_sr >> 1;
            end else if (tx_cnt == TX_STOP_BIT) begin
              line_lvl = 1'b1;
            end else begin
              tx_on = 1'b0;
            end
            if (tx_on) tx_cnt = tx_cnt + CNT_W'(1);
          end
        end
      end
      res.tx_line = line_lvl;
      res.rx_busy = rx_on;
      res.tx_busy = tx_on;
      line_status_q.push_back(res);
    endfunction

    task mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch %0d: %s", errors, msg);
    endtask

    task cmp(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        mismatch($sformatf("result %0d %s: got %0h expected %0h", checked, name, got, want));
    endtask

    task check_item(out_item_t got);
      out_item_t want;
      checked++;
      if (line_status_q.size() == 0) begin
        mismatch($sformatf("result %0d arrived with nothing expected", checked));
        return;
      end
      want = line_status_q.pop_front();
      cmp("tx_line", 8'(got.tx_line), 8'(want.tx_line));
      cmp("tx_taken", 8'(got.tx_taken), 8'(want.tx_taken));
      cmp("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
      cmp("rx_data", got.rx_data, want.rx_data);
      cmp("rx_busy", 8'(got.rx_busy), 8'(want.rx_busy));
      cmp("tx_busy", 8'(got.tx_busy), 8'(want.tx_busy));
    endtask
  endclass

  uart_scoreboard sb = new();

  logic [7:0] frame_byte  = 8'h00;
  logic       frame_good  = 1'b1;
  bit         send_gaps   = 1'b0;
  bit         recv_stalls = 1'b0;
  bit         hold_req    = 1'b0;
  int         hold_left   = 0;
  int         stall_left  = 0;

  tick_driven_uart_fractional_timing #(
    .PHASE_BITS(PH_W)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_item(out_item_o);
      stall_left = recv_stalls ? $urandom_range(0, 15) : 0;
    end
  end

  // result side: long hold-off on request, else per-item stall
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic in_item_t pack_item(logic act, logic lvl, logic vld, logic [7:0] b);
    in_item_t it;
    it.action   = act;
    it.rx_level = lvl;
    it.tx_valid = vld;
    it.tx_byte  = b;
    return it;
  endfunction

  // line level the sender of the current frame would show at this point
  function automatic logic frame_level();
    return (sb.rx_cnt < RX_DATA_BITS) ? frame_byte[sb.rx_cnt[2:0]] : frame_good;
  endfunction

  function automatic in_item_t make_item(bit noisy);
    in_item_t        it;
    logic [IN_W-1:0] raw;
    raw = IN_W'($urandom);
    if (noisy) return in_item_t'(raw);
    it.action   = ACT_TICK;
    it.rx_level = 1'b1;
    if (!sb.rx_on) begin
      if ($urandom_range(0, 5) == 0) begin
        it.action   = ACT_EDGE;
        it.rx_level = 1'($urandom_range(0, 1));
        frame_byte  = 8'($urandom);
        frame_good  = ($urandom_range(0, 7) != 0);
      end
    end else begin
      it.rx_level = frame_level();
      if ($urandom_range(0, 39) == 0) it.action = ACT_EDGE;
    end
    if (!sb.tx_on) begin
      it.tx_valid = ($urandom_range(0, 3) != 0);
      it.tx_byte  = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    end else begin
      it.tx_valid = 1'($urandom_range(0, 1));
      it.tx_byte  = 8'($urandom);
    end
    return it;
  endfunction

  task automatic wait_slot(int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drive_item(in_item_t it);
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    sb.set_reg(idx, v);
  endtask

  task automatic set_timing(logic [STEP_W-1:0] st, logic [PERIOD_W-1:0] per,
                            logic [RX_FIRST_W-1:0] rxf, logic [TX_FIRST_W-1:0] txf);
    cfg_write(CFG_PHASE_STEP, CFG_W'(st));
    cfg_write(CFG_BIT_PERIOD, CFG_W'(per));
    cfg_write(CFG_RX_FIRST_SAMPLE, CFG_W'(rxf));
    cfg_write(CFG_TX_FIRST_EDGE, CFG_W'(txf));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one full receive frame with an ignored edge inside, byte offered throughout
  task automatic rx_frame(logic [7:0] data, logic stop_ok, logic [7:0] offer);
    in_item_t it;
    int       n;
    n = 0;
    while (sb.rx_on) begin
      wait_slot(0);
      drive_item(pack_item(ACT_TICK, 1'b1, 1'b0, 8'h00));
    end
    frame_byte = data;
    frame_good = stop_ok;
    wait_slot(0);
    drive_item(pack_item(ACT_EDGE, 1'b0, 1'b1, offer));
    do begin
      wait_slot(0);
      it = pack_item((n == 3) ? ACT_EDGE : ACT_TICK, frame_level(), 1'b1, offer);
      drive_item(it);
      n++;
    end while (sb.rx_on);
  endtask

  initial begin
    in_item_t it;
    int       n;
    int       gap;
    bit       pressed;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    wait_slot(0);
    drive_item(pack_item(ACT_EDGE, 1'b0, 1'b1, 8'hFF));
    wait_slot(0);
    drive_item(pack_item(ACT_TICK, 1'b0, 1'b1, 8'h00));
    wait_slot(0);
    drive_item(pack_item(ACT_TICK, 1'b1, 1'b0, 8'hFF));
    drain();
    set_timing(4'd15, 6'd15, 7'd1, 6'd1);
    rx_frame(8'hA5, 1'b1, 8'h80);
    rx_frame(8'hFF, 1'b0, 8'h01);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: set_timing(STEP_RST, PERIOD_RST, RX_FIRST_RST, TX_FIRST_RST);
        1: set_timing(4'd15, 6'd63, 7'd127, 6'd63);
        2: set_timing(4'd1, 6'd2, 7'd1, 6'd1);
        3: set_timing(4'd15, 6'd2, 7'd1, 6'd63);
        default: set_timing(4'($urandom_range(1, 15)), 6'($urandom_range(2, 63)),
                            7'($urandom_range(1, 127)), 6'($urandom_range(1, 63)));
      endcase
      send_gaps   = !(p == 1 || p == 3);
      recv_stalls = !(p == 2 || p == 3);
      pressed     = 1'b0;
      n           = 0;
      while (n < RAND_ITEMS / PHASES) begin
        gap = send_gaps ? $urandom_range(0, 15) : 0;
        if (!pressed && n == 100) begin
          pressed = 1'b1;
          if (p == 4) hold_req = 1'b1;
          if (p == 5) drain();
        end
        wait_slot(gap);
        it = make_item($urandom_range(0, 4) == 0);
        if (!(it.action == ACT_EDGE && sb.rx_on)) n++;
        drive_item(it);
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- tick_driven_uart_fractional_timing.f -----
design/tdu_pkg.sv
design/tdu_phase.sv
design/tick_driven_uart_fractional_timing.sv
sim/tb_tick_driven_uart_fractional_timing.sv
